FILE: rtl/sep_pkg.sv
// Shared types and constants for the signal edge preconditioner.
// No dependencies; imported by every module of the block.
package sep_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int INDEX_W     = 16;
    localparam int COEF_FRAC   = 12;
    localparam int EDGE_LEN_W  = 4;
    localparam int SIG_LEN_W   = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] MAT_FWD_LEFT  = 2'd0;
    localparam logic [1:0] MAT_FWD_RIGHT = 2'd1;
    localparam logic [1:0] MAT_INV_LEFT  = 2'd2;
    localparam logic [1:0] MAT_INV_RIGHT = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNAL_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_MODE  = 2'd2;

    localparam logic [EDGE_LEN_W-1:0] EDGE_LENGTH_RST   = 4'd4;
    localparam logic [SIG_LEN_W-1:0]  SIGNAL_LENGTH_RST = 16'd1024;

endpackage

FILE: rtl/sep_round_sat.sv
// Round-half-up from Q.12 accumulator to integer, then saturate to 16 bits.
// Depends on sep_pkg.
module sep_round_sat import sep_pkg::*; #(
    parameter int ACC_W = 36
) (
    input  logic signed [ACC_W-1:0] acc_in,
    output sample_t                 value_out
);

    localparam int VW = ACC_W + 1;
    localparam int QW = VW - COEF_FRAC;
    localparam logic signed [VW-1:0] HALF  = VW'(1 << (COEF_FRAC - 1));
    localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
    localparam logic signed [QW-1:0] Q_MIN = -QW'(32768);

    logic signed [VW-1:0] v;
    logic signed [QW-1:0] q;

    always_comb begin
        v = {acc_in[ACC_W-1], acc_in} + HALF;
        q = v[VW-1:COEF_FRAC];
        if (q > Q_MAX) begin
            value_out = sample_t'(16'sh7fff);
        end else if (q < Q_MIN) begin
            value_out = sample_t'(16'sh8000);
        end else begin
            value_out = q[SAMPLE_W-1:0];
        end
    end

endmodule

FILE: rtl/signal_edge_preconditioner.sv
// A middle sample's result is valid the cycle after its transfer; middle samples sustain one
// transfer per cycle while m_ready is high. An edge-completing sample starts an N-row burst;
// each row takes N coefficient/buffer reads, a multiply, an accumulate and an output register
// step, so the input stalls for the whole burst, and longer while m_ready is low.
// Reset: sync active-low; clears control, count, registers to 4/1024/0; memories not cleared.
// Depends on sep_pkg and sep_round_sat.
module signal_edge_preconditioner import sep_pkg::*; #(
    parameter int EDGE_MAX    = 8,
    parameter int LENGTH_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic [1:0]             s_matrix_select,
    input  logic [2:0]             s_coef_row,
    input  logic [2:0]             s_coef_col,
    input  coef_t                  s_coef_value,
    input  sample_t                s_sample_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [INDEX_W-1:0]     m_out_index,
    output sample_t                m_out_value,
    output logic                   m_last_of_run
);

    localparam int EB_W       = (EDGE_MAX > 1) ? $clog2(EDGE_MAX) : 1;
    localparam int NW         = $clog2(EDGE_MAX + 1);
    localparam int COEF_DEPTH = 4 * EDGE_MAX * EDGE_MAX;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int CW         = (LENGTH_BITS + 8 > 17) ? LENGTH_BITS + 8 : 17;
    localparam int ACC_W      = PROD_W + $clog2(EDGE_MAX) + 1;
    localparam logic [CW-1:0] LEN_MASK = {{(CW - LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]             state_reg;
    logic [EDGE_LEN_W-1:0]  edge_len_reg;
    logic [SIG_LEN_W-1:0]   sig_len_reg;
    logic                   inv_mode_reg;
    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [INDEX_W-1:0]     m_index_reg;
    sample_t                m_value_reg;
    logic                   m_last_reg;

    logic [NW-1:0]          n_reg;
    logic [1:0]             mat_reg;
    logic [CW-1:0]          base_reg;
    logic [NW-1:0]          row_reg;
    logic [NW-1:0]          iss_k_reg;
    logic                   iss_on_reg;
    logic                   rd_v_reg;
    logic                   rd_last_reg;
    logic                   prod_v_reg;
    logic                   prod_last_reg;
    prod_t                  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    coef_t                  coef_mem [COEF_DEPTH];
    coef_t                  coef_rd_reg;
    sample_t                eb_mem [EDGE_MAX];
    sample_t                eb_rd_reg;

    logic [NW-1:0]          n_eff;
    logic [CW-1:0]          n_w, len_m, len_w, cnt_w, p_w, p1_w, rbase_w, rk_w, idx_w;
    logic                   is_left, is_right, done_left, done_right;
    logic                   out_free, sample_acc, load_acc, coef_we, eb_we;
    logic                   start_edge, load_mid, load_edge, row_last;
    logic [CA_W-1:0]        coef_waddr, coef_raddr;
    logic [EB_W-1:0]        eb_waddr;
    sample_t                rs_value;

    assign cfg_ready     = 1'b1;
    assign out_free      = !m_valid_reg || m_ready;
    assign s_ready       = (state_reg == S_IDLE) && out_free;
    assign sample_acc    = s_valid && s_ready && (s_command == CMD_SAMPLE);
    assign load_acc      = s_valid && s_ready && (s_command == CMD_LOAD);
    assign m_valid       = m_valid_reg;
    assign m_out_index   = m_index_reg;
    assign m_out_value   = m_value_reg;
    assign m_last_of_run = m_last_reg;

    always_comb begin
        if (edge_len_reg == '0) begin
            n_eff = NW'(1);
        end else if (int'(edge_len_reg) > EDGE_MAX) begin
            n_eff = NW'(EDGE_MAX);
        end else begin
            n_eff = NW'(edge_len_reg);
        end
        n_w     = CW'(n_eff);
        len_m   = CW'(sig_len_reg) & LEN_MASK;
        len_w   = (len_m < (n_w << 1)) ? (n_w << 1) : len_m;
        cnt_w   = CW'(count_reg);
        p_w     = (cnt_w >= len_w) ? '0 : cnt_w;
        p1_w    = p_w + CW'(1);
        count_next = (p1_w >= len_w) ? '0 : p1_w[LENGTH_BITS-1:0];
        rbase_w = len_w - n_w;
        rk_w    = p_w - rbase_w;
        is_left    = p_w < n_w;
        is_right   = !is_left && (p_w >= rbase_w);
        done_left  = is_left && (p1_w == n_w);
        done_right = is_right && (p1_w == len_w);
    end

    assign eb_we      = sample_acc && (is_left || is_right);
    assign eb_waddr   = is_left ? p_w[EB_W-1:0] : rk_w[EB_W-1:0];
    assign coef_we    = load_acc && (int'(s_coef_row) < EDGE_MAX)
                        && (int'(s_coef_col) < EDGE_MAX);
    assign coef_waddr = CA_W'(int'(s_matrix_select) * EDGE_MAX * EDGE_MAX
                        + int'(s_coef_row) * EDGE_MAX + int'(s_coef_col));
    assign coef_raddr = CA_W'(int'(mat_reg) * EDGE_MAX * EDGE_MAX
                        + int'(row_reg) * EDGE_MAX + int'(iss_k_reg));

    assign start_edge = sample_acc && (done_left || done_right);
    assign load_mid   = sample_acc && !is_left && !is_right;
    assign load_edge  = (state_reg == S_OUT) && out_free;
    assign row_last   = row_reg == (n_reg - NW'(1));
    assign acc_next   = acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign idx_w      = base_reg + CW'(row_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_mid || load_edge) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= s_coef_value;
        end
        coef_rd_reg <= coef_mem[coef_raddr];
    end

    always_ff @(posedge aclk) begin
        if (eb_we) begin
            eb_mem[eb_waddr] <= s_sample_value;
        end
        eb_rd_reg <= eb_mem[iss_k_reg[EB_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            edge_len_reg <= EDGE_LENGTH_RST;
            sig_len_reg  <= SIGNAL_LENGTH_RST;
            inv_mode_reg <= 1'b0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            iss_on_reg   <= 1'b0;
            rd_v_reg     <= 1'b0;
            prod_v_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_EDGE_LENGTH:   edge_len_reg <= cfg_data[EDGE_LEN_W-1:0];
                    CFG_SIGNAL_LENGTH: sig_len_reg  <= cfg_data[SIG_LEN_W-1:0];
                    CFG_INVERSE_MODE:  inv_mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (sample_acc) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
            rd_v_reg    <= iss_on_reg;
            prod_v_reg  <= rd_v_reg;
            case (state_reg)
                S_IDLE: begin
                    if (start_edge) begin
                        state_reg  <= S_MAC;
                        iss_on_reg <= 1'b1;
                    end
                end
                S_MAC: begin
                    if (iss_on_reg && (iss_k_reg == n_reg - NW'(1))) begin
                        iss_on_reg <= 1'b0;
                    end
                    if (prod_v_reg && prod_last_reg) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        if (row_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg  <= S_MAC;
                            iss_on_reg <= 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rd_last_reg   <= iss_on_reg && (iss_k_reg == n_reg - NW'(1));
        prod_last_reg <= rd_last_reg;
        prod_reg      <= eb_rd_reg * coef_rd_reg;
        if (start_edge) begin
            n_reg     <= n_eff;
            base_reg  <= done_left ? '0 : rbase_w;
            mat_reg   <= done_left ? (inv_mode_reg ? MAT_INV_LEFT : MAT_FWD_LEFT)
                                   : (inv_mode_reg ? MAT_INV_RIGHT : MAT_FWD_RIGHT);
            row_reg   <= '0;
            iss_k_reg <= '0;
            acc_reg   <= '0;
        end else if (load_edge) begin
            row_reg   <= row_reg + NW'(1);
            iss_k_reg <= '0;
            acc_reg   <= '0;
        end else begin
            if (state_reg == S_MAC && iss_on_reg) begin
                iss_k_reg <= iss_k_reg + NW'(1);
            end
            if (prod_v_reg) begin
                acc_reg <= acc_next;
            end
        end
        if (load_mid) begin
            m_index_reg <= p_w[INDEX_W-1:0];
            m_value_reg <= s_sample_value;
            m_last_reg  <= 1'b1;
        end else if (load_edge) begin
            m_index_reg <= idx_w[INDEX_W-1:0];
            m_value_reg <= rs_value;
            m_last_reg  <= row_last;
        end
    end

    sep_round_sat #(
        .ACC_W (ACC_W)
    ) u_round_sat (
        .acc_in    (acc_reg),
        .value_out (rs_value)
    );

    a_issue_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC && iss_on_reg) |-> (iss_k_reg < n_reg))
        else $error("coefficient read issued past edge length");

    a_prod_in_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_v_reg |-> (state_reg == S_MAC))
        else $error("product valid outside accumulate state");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (row_reg < n_reg))
        else $error("edge row beyond edge length");

    a_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free && row_last) |=> (state_reg == S_IDLE && !rd_v_reg))
        else $error("edge burst did not return to idle cleanly");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for signal_edge_preconditioner: coefficient loads, edge
// matrix bursts, pass-through samples, register changes and handshake stalls.
// Depends on sep_pkg and the block's RTL; the scoreboard predicts every result itself.
module testbench;
    import sep_pkg::*;

    localparam int EDGE_MAX = 8;
    localparam int INV_EDGE_LIMIT = 3;
    localparam int SETTLE_CYCLES = 2 * EDGE_MAX * (EDGE_MAX + 3);
    localparam int MAX_MISMATCH_REPORTS = 10;
    localparam int RANDOM_ITEMS = 80;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } edge_result_t;

    class precond_scoreboard;
        edge_result_t        expected_results[$];
        logic [COEF_W-1:0]   coef_mem[4 * EDGE_MAX * EDGE_MAX];
        logic [SAMPLE_W-1:0] edge_buf[EDGE_MAX];
        int                  sample_pos;
        logic [3:0]          edge_len;
        logic [15:0]         sig_len;
        logic                inv_mode;
        int                  failures;

        function new();
            sample_pos = 0;
            edge_len   = EDGE_LENGTH_RST;
            sig_len    = SIGNAL_LENGTH_RST;
            inv_mode   = 1'b0;
            failures   = 0;
            foreach (coef_mem[i]) coef_mem[i] = '0;
            foreach (edge_buf[i]) edge_buf[i] = '0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= MAX_MISMATCH_REPORTS) $display("%s", msg);
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_EDGE_LENGTH:   edge_len = data[3:0];
                CFG_SIGNAL_LENGTH: sig_len  = data;
                CFG_INVERSE_MODE:  inv_mode = data[0];
                default: ;
            endcase
        endfunction

        function int edge_span();
            int n;
            n = edge_len;
            if (n < 1) n = 1;
            if (n > EDGE_MAX) n = EDGE_MAX;
            return n;
        endfunction

        function int signal_span();
            int len;
            len = sig_len;
            if (len < 2 * edge_span()) len = 2 * edge_span();
            return len;
        endfunction

        // N rows of matrix times buffered edge, rounded half up, saturated
        function void emit_edge_rows(logic [1:0] mat, int n, int base);
            longint acc;
            longint q;
            edge_result_t res;
            int ci;
            for (int r = 0; r < n; r++) begin
                acc = 0;
                for (int k = 0; k < n; k++) begin
                    ci = int'(mat) * EDGE_MAX * EDGE_MAX + r * EDGE_MAX + k;
                    acc += longint'($signed(edge_buf[k])) * longint'($signed(coef_mem[ci]));
                end
                q = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                res.index = 16'(base + r);
                res.value = 16'(q);
                res.last  = (r + 1 == n);
                expected_results.push_back(res);
            end
        endfunction

        function void note_transfer(logic cmd, logic [1:0] sel, logic [2:0] row,
                                    logic [2:0] col, logic [15:0] coef, logic [15:0] sample);
            int n, len, p;
            edge_result_t res;
            if (cmd == CMD_LOAD) begin
                if (row < EDGE_MAX && col < EDGE_MAX)
                    coef_mem[int'(sel) * EDGE_MAX * EDGE_MAX + int'(row) * EDGE_MAX + int'(col)]
                        = coef;
                return;
            end
            n = edge_span();
            len = signal_span();
            p = sample_pos;
            if (p >= len) p = 0;
            sample_pos = (p + 1 >= len) ? 0 : p + 1;
            if (p < n) begin
                edge_buf[p] = sample;
                if (p + 1 == n) emit_edge_rows(inv_mode ? MAT_INV_LEFT : MAT_FWD_LEFT, n, 0);
            end else if (p >= len - n) begin
                edge_buf[p - (len - n)] = sample;
                if (p + 1 == len)
                    emit_edge_rows(inv_mode ? MAT_INV_RIGHT : MAT_FWD_RIGHT, n, len - n);
            end else begin
                res.index = 16'(p);
                res.value = sample;
                res.last  = 1'b1;
                expected_results.push_back(res);
            end
        endfunction

        function void check_output(logic [15:0] idx, logic [15:0] val, logic last);
            edge_result_t want;
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected result: index %0d value %0d last %0b",
                                       idx, $signed(val), last));
                return;
            end
            want = expected_results.pop_front();
            if (want.index !== idx || want.value !== val || want.last !== last)
                note_failure($sformatf(
                    "mismatch: expected index %0d value %0d last %0b, got %0d %0d %0b",
                    want.index, $signed(want.value), want.last, idx, $signed(val), last));
        endfunction

        function void flush_leftover();
            edge_result_t want;
            while (expected_results.size() != 0) begin
                want = expected_results.pop_front();
                note_failure($sformatf("missing result: index %0d value %0d last %0b",
                                       want.index, $signed(want.value), want.last));
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_command;
    logic [1:0]             s_matrix_select;
    logic [2:0]             s_coef_row;
    logic [2:0]             s_coef_col;
    coef_t                  s_coef_value;
    sample_t                s_sample_value;
    logic                   m_valid;
    logic                   m_ready;
    logic [INDEX_W-1:0]     m_out_index;
    sample_t                m_out_value;
    logic                   m_last_of_run;

    precond_scoreboard sb = new();
    bit no_idle = 1'b0;
    int rx_hold_cycles = 0;
    int random_sent = 0;

    signal_edge_preconditioner dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_matrix_select (s_matrix_select),
        .s_coef_row      (s_coef_row),
        .s_coef_col      (s_coef_col),
        .s_coef_value    (s_coef_value),
        .s_sample_value  (s_sample_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_index     (m_out_index),
        .m_out_value     (m_out_value),
        .m_last_of_run   (m_last_of_run)
    );

    always #5 aclk = ~aclk;

    function automatic int draw_wait();
        if (no_idle) return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [1:0] sel, input logic [2:0] row,
                             input logic [2:0] col, input logic [15:0] coef,
                             input logic [15:0] sample);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            if (s_valid) s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_command       <= cmd;
        s_matrix_select <= sel;
        s_coef_row      <= row;
        s_coef_col      <= col;
        s_coef_value    <= coef;
        s_sample_value  <= sample;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_transfer(cmd, sel, row, col, coef, sample);
    endtask

    task automatic load_coef(input logic [1:0] sel, input logic [2:0] row,
                             input logic [2:0] col, input logic [15:0] coef);
        send_item(CMD_LOAD, sel, row, col, coef, 16'($urandom));
    endtask

    task automatic send_sample(input logic [15:0] sample);
        send_item(CMD_SAMPLE, 2'($urandom), 3'($urandom), 3'($urandom), 16'($urandom), sample);
    endtask

    // cfg_valid stays high across back-to-back writes; lowered by end_config
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(idx, data);
    endtask

    task automatic end_config();
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_block();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_results.size() != 0);
    endtask

    task automatic run_phase(input int phase_no);
        int n, len, items, pause_at;
        logic [15:0] d;
        if (phase_no == 1) begin
            // receiver holds off while the sender streams back to back
            write_reg(CFG_EDGE_LENGTH, 16'd2);
            write_reg(CFG_SIGNAL_LENGTH, 16'd64);
            end_config();
            no_idle = 1'b1;
            rx_hold_cycles = 300;
            for (int i = 0; i < 48; i++) send_sample(pick_sample());
            no_idle = 1'b0;
            random_sent += 48;
            return;
        end
        if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
            d = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
            case ($urandom_range(0, 9))
                0: d[3:0] = 4'd0;
                1: d[3:0] = 4'($urandom_range(9, 15));
                default: d[3:0] = 4'($urandom_range(1, 8));
            endcase
            write_reg(CFG_EDGE_LENGTH, d);
        end
        if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
            n = sb.edge_span();
            case ($urandom_range(0, 11))
                0: d = 16'($urandom_range(0, 2 * n - 1));
                1: d = 16'hFFFF;
                2: d = 16'($urandom_range(100, 65535));
                default: d = 16'(2 * n + $urandom_range(0, 10));
            endcase
            write_reg(CFG_SIGNAL_LENGTH, d);
        end
        if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
            d = 16'($urandom);
            write_reg(CFG_INVERSE_MODE, d);
        end
        // inverse pair is only preloaded up to INV_EDGE_LIMIT
        if (sb.inv_mode && sb.edge_span() > INV_EDGE_LIMIT)
            write_reg(CFG_EDGE_LENGTH, 16'($urandom_range(1, INV_EDGE_LIMIT)));
        end_config();
        len = sb.signal_span();
        if (len > 64) items = $urandom_range(10, 30);
        else items = len * $urandom_range(1, 2) + $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
        pause_at = (phase_no == 0 || $urandom_range(0, 3) == 0) ? items / 2 : -1;
        for (int i = 0; i < items; i++) begin
            if (i == pause_at) pause_until_drained();
            if ($urandom_range(0, 11) == 0)
                load_coef(2'($urandom), 3'($urandom), 3'($urandom), pick_coef());
            else
                send_sample(pick_sample());
        end
        no_idle = 1'b0;
        random_sent += items;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_output(m_out_index, m_out_value, m_last_of_run);
    end

    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = draw_wait();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #8_000_000;
        $display("signal_edge_preconditioner test failed");
        $finish;
    end

    initial begin
        int phase_no;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        s_valid         <= 1'b0;
        s_command       <= CMD_LOAD;
        s_matrix_select <= MAT_FWD_LEFT;
        s_coef_row      <= '0;
        s_coef_col      <= '0;
        s_coef_value    <= '0;
        s_sample_value  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // forward pair fully defined; inverse pair up to INV_EDGE_LIMIT
        for (int m = 0; m < 4; m++)
            for (int r = 0; r < EDGE_MAX; r++)
                for (int c = 0; c < EDGE_MAX; c++)
                    if (m < 2 || (r < INV_EDGE_LIMIT && c < INV_EDGE_LIMIT))
                        load_coef(2'(m), 3'(r), 3'(c), pick_coef());
        drain_block();

        // widest edge fills the whole edge buffer, one middle sample
        write_reg(CFG_EDGE_LENGTH, 16'd8);
        write_reg(CFG_SIGNAL_LENGTH, 16'd17);
        write_reg(CFG_INVERSE_MODE, 16'd0);
        write_reg(CFG_UNUSED_INDEX, 16'($urandom));
        end_config();
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        for (int i = 0; i < 12; i++) send_sample(pick_sample());
        drain_block();

        // zero edge length and too-short signal, inverse pair
        write_reg(CFG_EDGE_LENGTH, 16'hFFF0);
        write_reg(CFG_SIGNAL_LENGTH, 16'd0);
        write_reg(CFG_INVERSE_MODE, 16'hFFFF);
        end_config();
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        load_coef(MAT_INV_LEFT, 3'd0, 3'd0, 16'h8000);
        load_coef(MAT_INV_RIGHT, 3'd0, 3'd0, 16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);
        drain_block();

        // longest signal, then shrink below the running count
        write_reg(CFG_EDGE_LENGTH, 16'd2);
        write_reg(CFG_SIGNAL_LENGTH, 16'hFFFF);
        write_reg(CFG_INVERSE_MODE, 16'd0);
        end_config();
        for (int i = 0; i < 5; i++) send_sample(pick_sample());
        drain_block();
        write_reg(CFG_EDGE_LENGTH, 16'd1);
        write_reg(CFG_SIGNAL_LENGTH, 16'd3);
        end_config();
        for (int i = 0; i < 3; i++) send_sample(pick_sample());

        phase_no = 0;
        while (random_sent < RANDOM_ITEMS) begin
            drain_block();
            run_phase(phase_no);
            phase_no++;
        end
        drain_block();
        sb.flush_leftover();
        if (sb.failures == 0) begin
            $display("signal_edge_preconditioner test passed");
        end else begin
            $display("signal_edge_preconditioner test failed");
        end
        $finish;
    end
endmodule
